[src/silq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package silq_pkg;

    // Channels covered by the configuration registers and the wide pin fields
    localparam int CFG_CH       = 8;
    localparam int CHANNELS_DEF = 8;
    localparam int LOCK_W       = 10;
    localparam int CFG_W        = 24;
    localparam int CFG_IDX_W    = 3;

    // Item operations
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_PIN    = 2'd1;
    localparam logic [1:0] OP_RESYNC = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODES     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIONS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FUNCTIONS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOMING    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PROBING   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT   = 3'd5;

    // Reset values
    localparam logic [15:0]       MODES_RST   = 16'h5555;
    localparam logic [LOCK_W-1:0] LOCKOUT_RST = 10'd50;

    // Channel modes
    localparam logic [1:0] MODE_NO = 2'd1;
    localparam logic [1:0] MODE_NC = 2'd2;

    // Actions
    localparam logic [2:0] ACT_STOP      = 3'd1;
    localparam logic [2:0] ACT_FAST_STOP = 3'd2;
    localparam logic [2:0] ACT_HALT      = 3'd3;
    localparam logic [2:0] ACT_PANIC     = 3'd4;
    localparam logic [2:0] ACT_RESET     = 3'd5;

    // Functions
    localparam logic [1:0] FUNC_LIMIT     = 2'd1;
    localparam logic [1:0] FUNC_INTERLOCK = 2'd2;
    localparam logic [1:0] FUNC_SHUTDOWN  = 2'd3;

    // Edge kinds
    localparam logic [1:0] EDGE_NONE     = 2'd0;
    localparam logic [1:0] EDGE_LEADING  = 2'd1;
    localparam logic [1:0] EDGE_TRAILING = 2'd2;

    // Function events
    localparam logic [2:0] FEV_NONE      = 3'd0;
    localparam logic [2:0] FEV_LIMIT     = 3'd1;
    localparam logic [2:0] FEV_SHUTDOWN  = 3'd2;
    localparam logic [2:0] FEV_DISENGAGE = 3'd3;
    localparam logic [2:0] FEV_REENGAGE  = 3'd4;

    typedef struct packed {
        logic [15:0]       modes;
        logic [23:0]       actions;
        logic [15:0]       functions;
        logic [7:0]        homing;
        logic [7:0]        probing;
        logic [LOCK_W-1:0] lock_ticks;
    } cfg_t;

    typedef struct packed {
        logic [2:0] event_channel;
        logic       change_taken;
        logic [1:0] edge_kind;
        logic       hold_request;
        logic       halt_request;
        logic       panic_request;
        logic       hard_reset_request;
        logic       snapshot_request;
        logic [2:0] function_event;
        logic       report_request;
        logic [7:0] active_levels;
    } result_t;

endpackage

`default_nettype wire

[src/silq_eval.sv]
`timescale 1ns / 1ps
`default_nettype none

module silq_eval #(
    parameter int CHANNELS = silq_pkg::CHANNELS_DEF
) (
    input  wire logic [1:0]                   op,
    input  wire logic [2:0]                   channel,
    input  wire logic                         pin_level,
    input  wire logic [7:0]                   raw_pins,
    input  wire silq_pkg::cfg_t               cfg,
    input  wire logic [CHANNELS-1:0]          level_cur,
    input  wire logic [silq_pkg::LOCK_W-1:0]  lockout_cur [CHANNELS],
    output logic [CHANNELS-1:0]               level_next,
    output logic [silq_pkg::LOCK_W-1:0]       lockout_next [CHANNELS],
    output silq_pkg::result_t                 res
);

    logic [1:0]          ch_mode [CHANNELS];
    logic [CHANNELS-1:0] ch_en;
    logic [CHANNELS-1:0] ch_raw;

    logic [1:0] sel_mode;
    logic [2:0] sel_act;
    logic [1:0] sel_fn;
    logic       sel_probe;
    logic       sel_lvl;
    logic       sel_lock_zero;
    logic       ch_ok;
    logic       pin_op;
    logic       sel_en;
    logic       lv;
    logic       take;

    // Channels past the register width are always disabled
    for (genvar g = 0; g < CHANNELS; g++) begin : g_ch
        if (g < silq_pkg::CFG_CH) begin : g_cfg
            assign ch_mode[g] = cfg.modes[2*g +: 2];
            assign ch_raw[g]  = raw_pins[g];
        end else begin : g_none
            assign ch_mode[g] = 2'b00;
            assign ch_raw[g]  = 1'b0;
        end
        assign ch_en[g] = (ch_mode[g] == silq_pkg::MODE_NO)
                       || (ch_mode[g] == silq_pkg::MODE_NC);
    end

    assign sel_mode  = cfg.modes[{channel, 1'b0} +: 2];
    assign sel_act   = cfg.actions[({2'b00, channel} * 5'd3) +: 3];
    assign sel_fn    = cfg.functions[{channel, 1'b0} +: 2];
    assign sel_probe = cfg.homing[channel] | cfg.probing[channel];

    always_comb
    begin
        sel_lvl       = 1'b0;
        sel_lock_zero = 1'b0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (int'(channel) == i)
            begin
                sel_lvl       = level_cur[i];
                sel_lock_zero = (lockout_cur[i] == '0);
            end
        end

        ch_ok  = int'(channel) < CHANNELS;
        pin_op = (op == silq_pkg::OP_PIN) && ch_ok;
        sel_en = (sel_mode == silq_pkg::MODE_NO) || (sel_mode == silq_pkg::MODE_NC);
        lv     = (sel_mode == silq_pkg::MODE_NO) ? ~pin_level : pin_level;
        take   = pin_op && sel_en && sel_lock_zero && (lv != sel_lvl);

        for (int i = 0; i < CHANNELS; i++)
        begin
            level_next[i]   = level_cur[i];
            lockout_next[i] = lockout_cur[i];
            case (op)
                silq_pkg::OP_TICK:
                begin
                    if (lockout_cur[i] != '0)
                        lockout_next[i] = lockout_cur[i] - 1'b1;
                end
                silq_pkg::OP_RESYNC:
                begin
                    if (ch_en[i])
                    begin
                        level_next[i]   = (ch_mode[i] == silq_pkg::MODE_NO) ?
                                          ~ch_raw[i] : ch_raw[i];
                        lockout_next[i] = '0;
                    end
                    else
                        level_next[i] = 1'b0;
                end
                silq_pkg::OP_PIN:
                begin
                    if (pin_op && int'(channel) == i)
                    begin
                        if (!ch_en[i])
                            level_next[i] = 1'b0;
                        else if (take)
                        begin
                            level_next[i]   = lv;
                            lockout_next[i] = cfg.lock_ticks;
                        end
                    end
                end
                default: ;
            endcase
        end

        // disabled channels read inactive
        res.active_levels = '0;
        for (int i = 0; i < CHANNELS && i < silq_pkg::CFG_CH; i++)
            res.active_levels[i] = level_next[i] & ch_en[i];

        res.event_channel      = pin_op ? channel : 3'd0;
        res.change_taken       = take;
        res.edge_kind          = silq_pkg::EDGE_NONE;
        res.hold_request       = 1'b0;
        res.halt_request       = 1'b0;
        res.panic_request      = 1'b0;
        res.hard_reset_request = 1'b0;
        res.snapshot_request   = 1'b0;
        res.function_event     = silq_pkg::FEV_NONE;
        res.report_request     = 1'b0;

        if (take)
        begin
            res.edge_kind = lv ? silq_pkg::EDGE_LEADING : silq_pkg::EDGE_TRAILING;
            if (sel_probe)
            begin
                // homing / probing: snapshot on the leading edge only
                res.hold_request     = lv;
                res.snapshot_request = lv;
            end
            else
            begin
                res.report_request = 1'b1;
                if (lv)
                begin
                    case (sel_act)
                        silq_pkg::ACT_STOP,
                        silq_pkg::ACT_FAST_STOP: res.hold_request       = 1'b1;
                        silq_pkg::ACT_HALT:      res.halt_request       = 1'b1;
                        silq_pkg::ACT_PANIC:     res.panic_request      = 1'b1;
                        silq_pkg::ACT_RESET:     res.hard_reset_request = 1'b1;
                        default: ;
                    endcase
                    case (sel_fn)
                        silq_pkg::FUNC_LIMIT:     res.function_event = silq_pkg::FEV_LIMIT;
                        silq_pkg::FUNC_SHUTDOWN:  res.function_event = silq_pkg::FEV_SHUTDOWN;
                        silq_pkg::FUNC_INTERLOCK: res.function_event = silq_pkg::FEV_DISENGAGE;
                        default: ;
                    endcase
                end
                else if (sel_fn == silq_pkg::FUNC_INTERLOCK)
                    res.function_event = silq_pkg::FEV_REENGAGE;
            end
        end
    end

endmodule

`default_nettype wire

[src/silq_outbuf.sv]
`timescale 1ns / 1ps
`default_nettype none

// Result register with a skid stage behind it
module silq_outbuf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire silq_pkg::result_t push_data,
    output logic                   can_push,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output silq_pkg::result_t      out_data
);

    logic              main_valid_reg;
    logic              skid_valid_reg;
    silq_pkg::result_t main_reg;
    silq_pkg::result_t skid_reg;
    logic              pop;

    assign pop       = main_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || pop)
            main_valid_reg <= push;
        else if (push)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                main_reg <= skid_reg;
        end
        else if (!main_valid_reg || pop)
        begin
            if (push)
                main_reg <= push_data;
        end
        else if (push)
            skid_reg <= push_data;
    end

endmodule

`default_nettype wire

[src/switch_input_lockout_qualifier_core.sv]
// Each accepted item's result is registered, in the skid stage if the result register is full.
// Throughput: one item per cycle; the whole update is one pass of logic
// between the input port and the result register, with a skid stage behind it.
// The input stalls only when both the result register and the skid stage hold.
// Reset (rst_n, asynchronous): levels inactive, lockouts zero, registers at
// their documented defaults, output empty.
`timescale 1ns / 1ps
`default_nettype none

module switch_input_lockout_qualifier_core #(
    parameter int CHANNELS = silq_pkg::CHANNELS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           cfg_we,
    input  wire logic [silq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [silq_pkg::CFG_W-1:0]     cfg_data,

    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [1:0]                     op,
    input  wire logic [2:0]                     channel,
    input  wire logic                           pin_level,
    input  wire logic [7:0]                     raw_pins,

    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [2:0]                          event_channel,
    output logic                                change_taken,
    output logic [1:0]                          edge_kind,
    output logic                                hold_request,
    output logic                                halt_request,
    output logic                                panic_request,
    output logic                                hard_reset_request,
    output logic                                snapshot_request,
    output logic [2:0]                          function_event,
    output logic                                report_request,
    output logic [7:0]                          active_levels
);

    silq_pkg::cfg_t                cfg_reg;
    logic [CHANNELS-1:0]           level_reg;
    logic [CHANNELS-1:0]           level_next;
    logic [silq_pkg::LOCK_W-1:0]   lockout_reg  [CHANNELS];
    logic [silq_pkg::LOCK_W-1:0]   lockout_next [CHANNELS];
    silq_pkg::result_t             res;
    silq_pkg::result_t             out_data;
    logic                          xfer;

    assign xfer = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.modes      <= silq_pkg::MODES_RST;
            cfg_reg.actions    <= '0;
            cfg_reg.functions  <= '0;
            cfg_reg.homing     <= '0;
            cfg_reg.probing    <= '0;
            cfg_reg.lock_ticks <= silq_pkg::LOCKOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                silq_pkg::REG_MODES:     cfg_reg.modes      <= cfg_data[15:0];
                silq_pkg::REG_ACTIONS:   cfg_reg.actions    <= cfg_data[23:0];
                silq_pkg::REG_FUNCTIONS: cfg_reg.functions  <= cfg_data[15:0];
                silq_pkg::REG_HOMING:    cfg_reg.homing     <= cfg_data[7:0];
                silq_pkg::REG_PROBING:   cfg_reg.probing    <= cfg_data[7:0];
                silq_pkg::REG_LOCKOUT:   cfg_reg.lock_ticks <= cfg_data[silq_pkg::LOCK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
                lockout_reg[i] <= '0;
        end
        else if (xfer)
        begin
            level_reg <= level_next;
            for (int i = 0; i < CHANNELS; i++)
                lockout_reg[i] <= lockout_next[i];
        end
    end

    silq_eval #(
        .CHANNELS(CHANNELS)
    ) u_eval (
        .op          (op),
        .channel     (channel),
        .pin_level   (pin_level),
        .raw_pins    (raw_pins),
        .cfg         (cfg_reg),
        .level_cur   (level_reg),
        .lockout_cur (lockout_reg),
        .level_next  (level_next),
        .lockout_next(lockout_next),
        .res         (res)
    );

    silq_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (xfer),
        .push_data(res),
        .can_push (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    assign event_channel      = out_data.event_channel;
    assign change_taken       = out_data.change_taken;
    assign edge_kind          = out_data.edge_kind;
    assign hold_request       = out_data.hold_request;
    assign halt_request       = out_data.halt_request;
    assign panic_request      = out_data.panic_request;
    assign hard_reset_request = out_data.hard_reset_request;
    assign snapshot_request   = out_data.snapshot_request;
    assign function_event     = out_data.function_event;
    assign report_request     = out_data.report_request;
    assign active_levels      = out_data.active_levels;

    // input only backs up when a result is waiting
    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

    a_take_has_edge: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && res.change_taken |-> res.edge_kind != silq_pkg::EDGE_NONE)
        else $error("accepted change without an edge");

    a_snapshot_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && res.snapshot_request |->
            res.function_event == silq_pkg::FEV_NONE && !res.report_request
            && res.hold_request)
        else $error("snapshot mixed with normal-mode requests");

    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        xfer |-> $onehot0({res.hold_request, res.halt_request,
                           res.panic_request, res.hard_reset_request}))
        else $error("more than one action raised");

    a_tick_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && op != silq_pkg::OP_PIN |=> level_reg == $past(level_next)
            && !$past(res.change_taken))
        else $error("non-pin item produced a change");

endmodule

`default_nettype wire

[verif/switch_input_lockout_qualifier_core_tb.sv]
`timescale 1ns / 1ps

module switch_input_lockout_qualifier_core_tb;

    import silq_pkg::*;

    localparam logic [1:0] OP_IDLE   = 2'd3;
    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_RSVD = 2'd3;

    localparam int RDY_ALWAYS  = 0;
    localparam int RDY_RANDOM  = 1;
    localparam int RDY_PATTERN = 2;
    localparam int LONG_HOLD   = 60;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_MODES;
    logic [CFG_W-1:0]   cfg_data  = '0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [1:0]         op        = OP_TICK;
    logic [2:0]         channel   = '0;
    logic               pin_level = 1'b0;
    logic [7:0]         raw_pins  = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [2:0]         event_channel;
    logic               change_taken;
    logic [1:0]         edge_kind;
    logic               hold_request;
    logic               halt_request;
    logic               panic_request;
    logic               hard_reset_request;
    logic               snapshot_request;
    logic [2:0]         function_event;
    logic               report_request;
    logic [7:0]         active_levels;

    // Shadow of the block's registers and per-channel state
    cfg_t              cfg_shadow;
    logic              chan_level   [CFG_CH];
    logic [LOCK_W-1:0] chan_lockout [CFG_CH];

    result_t pending_results[$];
    result_t want;
    int      mismatch_count = 0;

    int          ready_mode    = RDY_ALWAYS;
    logic [15:0] ready_pattern = 16'hFFFF;
    bit          long_hold_req = 1'b0;
    int          hold_left     = 0;

    switch_input_lockout_qualifier_core i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .op                 (op),
        .channel            (channel),
        .pin_level          (pin_level),
        .raw_pins           (raw_pins),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .event_channel      (event_channel),
        .change_taken       (change_taken),
        .edge_kind          (edge_kind),
        .hold_request       (hold_request),
        .halt_request       (halt_request),
        .panic_request      (panic_request),
        .hard_reset_request (hard_reset_request),
        .snapshot_request   (snapshot_request),
        .function_event     (function_event),
        .report_request     (report_request),
        .active_levels      (active_levels)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Modes 0 and 3 both count as disabled
    function automatic logic [1:0] mode_of(int ch);
        logic [1:0] m;
        m = cfg_shadow.modes[2*ch +: 2];
        return (m == MODE_NO || m == MODE_NC) ? m : MODE_OFF;
    endfunction

    function automatic result_t qualify_item(logic [1:0] kind, logic [2:0] ch, logic pin,
                                             logic [7:0] raw);
        result_t    r;
        logic [1:0] m;
        logic       lv;
        logic [2:0] act;
        logic [1:0] fn;
        r = '0;
        case (kind)
            OP_TICK:
            begin
                for (int i = 0; i < CFG_CH; i++)
                    if (chan_lockout[i] != '0)
                        chan_lockout[i] = chan_lockout[i] - 1'b1;
            end
            OP_RESYNC:
            begin
                for (int i = 0; i < CFG_CH; i++)
                begin
                    m = mode_of(i);
                    if (m == MODE_OFF)
                        chan_level[i] = 1'b0;
                    else
                    begin
                        chan_level[i]   = (m == MODE_NO) ? ~raw[i] : raw[i];
                        chan_lockout[i] = '0;
                    end
                end
            end
            OP_PIN:
            begin
                m = mode_of(ch);
                r.event_channel = ch;
                if (m == MODE_OFF)
                    chan_level[ch] = 1'b0;
                else if (chan_lockout[ch] == '0)
                begin
                    lv = (m == MODE_NO) ? ~pin : pin;
                    if (lv != chan_level[ch])
                    begin
                        chan_level[ch]   = lv;
                        chan_lockout[ch] = cfg_shadow.lock_ticks;
                        r.change_taken   = 1'b1;
                        r.edge_kind      = lv ? EDGE_LEADING : EDGE_TRAILING;
                        if (cfg_shadow.homing[ch] || cfg_shadow.probing[ch])
                        begin
                            r.hold_request     = lv;
                            r.snapshot_request = lv;
                        end
                        else
                        begin
                            act = cfg_shadow.actions[3*ch +: 3];
                            fn  = cfg_shadow.functions[2*ch +: 2];
                            if (lv)
                            begin
                                case (act)
                                    ACT_STOP, ACT_FAST_STOP: r.hold_request = 1'b1;
                                    ACT_HALT:  r.halt_request       = 1'b1;
                                    ACT_PANIC: r.panic_request      = 1'b1;
                                    ACT_RESET: r.hard_reset_request = 1'b1;
                                    default: ;
                                endcase
                                case (fn)
                                    FUNC_LIMIT:     r.function_event = FEV_LIMIT;
                                    FUNC_SHUTDOWN:  r.function_event = FEV_SHUTDOWN;
                                    FUNC_INTERLOCK: r.function_event = FEV_DISENGAGE;
                                    default: ;
                                endcase
                            end
                            else if (fn == FUNC_INTERLOCK)
                                r.function_event = FEV_REENGAGE;
                            r.report_request = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        for (int i = 0; i < CFG_CH; i++)
            r.active_levels[i] = (mode_of(i) != MODE_OFF) && chan_level[i];
        return r;
    endfunction

    task automatic log_mismatch(string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned exp_val);
        if (got != exp_val)
            log_mismatch($sformatf("%s got %0d, want %0d", name, got, exp_val));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (pending_results.size() == 0)
                log_mismatch("result transfer with nothing outstanding");
            else
            begin
                want = pending_results.pop_front();
                check_field("event_channel", event_channel, want.event_channel);
                check_field("change_taken", change_taken, want.change_taken);
                check_field("edge_kind", edge_kind, want.edge_kind);
                check_field("hold_request", hold_request, want.hold_request);
                check_field("halt_request", halt_request, want.halt_request);
                check_field("panic_request", panic_request, want.panic_request);
                check_field("hard_reset_request", hard_reset_request,
                            want.hard_reset_request);
                check_field("snapshot_request", snapshot_request, want.snapshot_request);
                check_field("function_event", function_event, want.function_event);
                check_field("report_request", report_request, want.report_request);
                check_field("active_levels", active_levels, want.active_levels);
            end
        end
    end

    // Receiver: long hold-off on request, otherwise the selected stall style
    always @(posedge clk)
    begin
        if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            case (ready_mode)
                RDY_ALWAYS: out_ready <= 1'b1;
                RDY_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    out_ready     <= ready_pattern[0];
                    ready_pattern  = {ready_pattern[0], ready_pattern[15:1]};
                end
            endcase
        end
    end

    task automatic send_item(logic [1:0] kind, logic [2:0] ch, logic pin, logic [7:0] raw);
        in_valid  <= 1'b1;
        op        <= kind;
        channel   <= ch;
        pin_level <= pin;
        raw_pins  <= raw;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        pending_results.push_back(qualify_item(kind, ch, pin, raw));
    endtask

    task automatic gap(int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every outstanding result has been taken
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_MODES:     cfg_shadow.modes      = data[15:0];
            REG_ACTIONS:   cfg_shadow.actions    = data[23:0];
            REG_FUNCTIONS: cfg_shadow.functions  = data[15:0];
            REG_HOMING:    cfg_shadow.homing     = data[7:0];
            REG_PROBING:   cfg_shadow.probing    = data[7:0];
            REG_LOCKOUT:   cfg_shadow.lock_ticks = data[LOCK_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_regs(logic [CFG_W-1:0] modes, logic [CFG_W-1:0] acts,
                              logic [CFG_W-1:0] fns, logic [CFG_W-1:0] hom,
                              logic [CFG_W-1:0] prb, logic [CFG_W-1:0] lock);
        write_reg(REG_MODES, modes);
        write_reg(REG_ACTIONS, acts);
        write_reg(REG_FUNCTIONS, fns);
        write_reg(REG_HOMING, hom);
        write_reg(REG_PROBING, prb);
        write_reg(REG_LOCKOUT, lock);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Registers at their reset values: all normally open, 50 tick lockout
    task automatic test_default_lockout();
        send_item(OP_RESYNC, 3'd0, 1'b0, 8'h00);
        send_item(OP_PIN, 3'd0, 1'b0, 8'h00);
        send_item(OP_PIN, 3'd0, 1'b1, 8'h00);
        send_item(OP_PIN, 3'd0, 1'b0, 8'h00);
        repeat (LOCKOUT_RST - 1) send_item(OP_TICK, 3'd0, 1'b0, 8'h00);
        send_item(OP_PIN, 3'd0, 1'b0, 8'h00);
        send_item(OP_TICK, 3'd0, 1'b0, 8'h00);
        send_item(OP_PIN, 3'd0, 1'b0, 8'h00);
        send_item(OP_RESYNC, 3'd0, 1'b0, 8'hFF);
    endtask

    // Channel i gets action code i and function code i mod 4, zero lockout
    task automatic test_actions_functions();
        logic [CFG_W-1:0] acts;
        logic [CFG_W-1:0] fns;
        acts = '0;
        fns  = '0;
        for (int i = 0; i < CFG_CH; i++)
        begin
            acts[3*i +: 3] = 3'(i);
            fns[2*i +: 2]  = 2'(i);
        end
        settle();
        write_regs(24'h00AAAA, acts, fns, '0, '0, '0);
        send_item(OP_RESYNC, 3'd0, 1'b0, 8'h00);
        for (int i = 0; i < CFG_CH; i++)
        begin
            send_item(OP_PIN, 3'(i), 1'b1, 8'h00);
            send_item(OP_PIN, 3'(i), 1'b0, 8'h00);
        end
    endtask

    // Homing and probing act alike; both only act on a leading edge
    task automatic test_homing_probing();
        logic [CFG_W-1:0] acts;
        logic [CFG_W-1:0] fns;
        acts = '0;
        fns  = '0;
        for (int i = 0; i < CFG_CH; i++)
        begin
            acts[3*i +: 3] = ACT_PANIC;
            fns[2*i +: 2]  = FUNC_INTERLOCK;
        end
        settle();
        write_regs(24'h005555, acts, fns, 24'h00000F, 24'h00003C, '0);
        send_item(OP_RESYNC, 3'd0, 1'b0, 8'hFF);
        for (int i = 0; i < CFG_CH; i += 2)
        begin
            send_item(OP_PIN, 3'(i), 1'b0, 8'h00);
            send_item(OP_PIN, 3'(i), 1'b1, 8'h00);
        end
    endtask

    // Disabled and reserved modes, the longest lockout, lockout kept across
    // a resync of a disabled channel, levels kept across mode changes
    task automatic test_disabled_channels();
        settle();
        write_regs(24'h00AA9C, '0, '0, '0, '0, 24'h0003FF);
        send_item(OP_RESYNC, 3'd0, 1'b0, 8'h0F);
        send_item(OP_PIN, 3'd0, 1'b1, 8'h00);
        send_item(OP_PIN, 3'd1, 1'b0, 8'h00);
        send_item(OP_PIN, 3'd3, 1'b0, 8'h00);
        send_item(OP_PIN, 3'd3, 1'b1, 8'h00);
        send_item(OP_PIN, 3'd2, 1'b0, 8'h00);
        send_item(OP_IDLE, 3'd7, 1'b1, 8'hFF);
        settle();
        write_regs(24'h00AA8C, '0, '0, '0, '0, 24'h0003FF);
        send_item(OP_TICK, 3'd0, 1'b0, 8'h00);
        send_item(OP_RESYNC, 3'd0, 1'b0, 8'hF0);
        settle();
        write_regs(24'h00A89C, '0, '0, '0, '0, '0);
        send_item(OP_TICK, 3'd0, 1'b0, 8'h00);
        settle();
        write_regs(24'h00AA9C, '0, '0, '0, '0, '0);
        send_item(OP_PIN, 3'd2, 1'b0, 8'h00);
        send_item(OP_PIN, 3'd3, 1'b1, 8'h00);
        send_item(OP_PIN, 3'd3, 1'b0, 8'h00);
    endtask

    // Receiver holds off while items keep coming, so the input has to stall
    task automatic test_backpressure();
        settle();
        write_regs(24'h005555, 24'h123456, 24'h00E4E4, '0, '0, '0);
        ready_mode    = RDY_ALWAYS;
        long_hold_req = 1'b1;
        repeat (24)
            send_item($urandom_range(0, 1) ? OP_PIN : OP_TICK, 3'($urandom), 1'($urandom),
                      8'($urandom));
        settle();
    endtask

    function automatic logic [CFG_W-1:0] random_modes();
        logic [CFG_W-1:0] m;
        m = CFG_W'($urandom);
        for (int i = 0; i < CFG_CH; i++)
        begin
            case ($urandom_range(0, 9))
                0:       m[2*i +: 2] = MODE_OFF;
                1:       m[2*i +: 2] = MODE_RSVD;
                default: m[2*i +: 2] = $urandom_range(0, 1) ? MODE_NO : MODE_NC;
            endcase
        end
        return m;
    endfunction

    function automatic logic [CFG_W-1:0] random_lockout();
        logic [CFG_W-1:0] v;
        v = CFG_W'($urandom);
        case ($urandom_range(0, 9))
            0:       v[LOCK_W-1:0] = '0;
            1:       v[LOCK_W-1:0] = 10'd1;
            2:       v[LOCK_W-1:0] = 10'd1023;
            3:       v[LOCK_W-1:0] = LOCK_W'($urandom_range(5, 20));
            default: v[LOCK_W-1:0] = LOCK_W'($urandom_range(1, 4));
        endcase
        return v;
    endfunction

    task automatic send_random_item();
        int         pick;
        logic [1:0] kind;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            kind = OP_PIN;
        else if (pick < 85)
            kind = OP_TICK;
        else if (pick < 95)
            kind = OP_RESYNC;
        else
            kind = OP_IDLE;
        send_item(kind, 3'($urandom), 1'($urandom), 8'($urandom));
    endtask

    task automatic test_random_traffic();
        int sent;
        int burst;
        for (int phase = 0; phase < 9; phase++)
        begin
            settle();
            case (phase)
                0: write_regs('1, '1, '1, '1, '1, '1);
                1: write_regs(24'h00AAAA, '1, 24'h00FFFF, '0, '0, '0);
                default:
                    write_regs(random_modes(), CFG_W'($urandom), CFG_W'($urandom),
                               CFG_W'($urandom & $urandom & $urandom),
                               CFG_W'($urandom & $urandom & $urandom), random_lockout());
            endcase
            ready_mode    = $urandom_range(RDY_ALWAYS, RDY_PATTERN);
            ready_pattern = 16'($urandom) | 16'h0101;
            sent = 0;
            while (sent < 80)
            begin
                burst = $urandom_range(1, 12);
                repeat (burst)
                begin
                    send_random_item();
                    sent++;
                end
                gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5));
            end
        end
    endtask

    initial
    begin
        cfg_shadow = '{modes: MODES_RST, actions: '0, functions: '0, homing: '0,
                       probing: '0, lock_ticks: LOCKOUT_RST};
        foreach (chan_level[i])
        begin
            chan_level[i]   = 1'b0;
            chan_lockout[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_lockout();
        test_actions_functions();
        test_homing_probing();
        test_disabled_channels();
        test_backpressure();
        test_random_traffic();
        settle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
